// ----- rtl/core/nggp_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA parser package
// Shared types, character codes and the base-60 long-division digit step.
// ----------------------------------------------------------------------------
package nggp_pkg;

   // Position minutes are carried as a running quotient/remainder by 60 of
   // the minute digits followed by six fraction digits (millionths of a minute).
   localparam int QUO_W      = 21;
   localparam int FRAC_CNT_W = 3;
   localparam logic [FRAC_CNT_W-1:0] TOTAL_FRAC = 3'd6;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_E      = 8'h45;

   localparam logic CSR_ZONE_HOURS   = 1'b0;
   localparam logic CSR_ZONE_MINUTES = 1'b1;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic [5:0]       rem;
   } div60_type;

   // Snapshot handed from the byte parser to the result unit.
   typedef struct packed {
      logic                  start;
      logic [6:0]            hour;
      logic [6:0]            minute;
      logic [6:0]            second;
      logic [6:0]            lat_deg;
      div60_type             lat_div;
      logic [FRAC_CNT_W-1:0] lat_pad;
      logic [9:0]            lon_deg;
      div60_type             lon_div;
      logic [FRAC_CNT_W-1:0] lon_pad;
   } fix_type;

   // Header text after the dollar sign.
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h47;
         3'd1:    ch = 8'h50;
         3'd2:    ch = 8'h47;
         3'd3:    ch = 8'h47;
         3'd4:    ch = 8'h41;
         3'd5:    ch = CH_COMMA;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Appends one decimal digit to a number held as quotient and remainder by 60.
   function automatic div60_type div60_step(input div60_type cur, input logic [3:0] digit);
      logic [9:0] t;
      logic [3:0] qd;
      div60_type  res;
      t  = 10'(cur.rem) * 10'd10 + 10'(digit);
      qd = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (t >= 10'(k * 60)) begin
            qd = 4'(k);
         end
      end
      res.quo = QUO_W'(cur.quo * QUO_W'(10)) + QUO_W'(qd);
      res.rem = 6'(t - 10'(qd) * 10'd60);
      return res;
   endfunction

endpackage

// ----- rtl/core/nmea_gga_time_position_parser.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA time and position parser
// Hunts for GGA sentences in a byte stream and reports local time and
// north/east position in microdegrees for each complete sentence.
// ----------------------------------------------------------------------------
//  Channel | Ports                          | Direction | Moves
//  --------+--------------------------------+-----------+--------------------------
//  req     | req_valid/ready, req_char_byte | in        | one received byte
//  rsp     | rsp_valid/ready, rsp_local_*,  | out       | one parsed fix
//          | rsp_*_microdeg                 |           |
//  csr     | csr_wr_en, csr_index, csr_wdata| in        | zone offset hours/minutes
//
// One byte is taken per cycle; the byte parser keeps running digit sums and a
// base-60 quotient of the minutes as bytes arrive. After the final 'E' transfer
// the result unit pads the minute fractions with zero digits, does one multiply
// and one add (once its output is free) before rsp_valid rises.
// req_ready drops only for the east-hemisphere byte while the result unit is still busy.
// Reset is synchronous; it restores zone offsets of 4 h 30 min.
// ----------------------------------------------------------------------------
module nmea_gga_time_position_parser #(
   parameter int FRACTION_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_local_hour,
   output logic [5:0]  rsp_local_minute,
   output logic [5:0]  rsp_local_second,
   output logic [26:0] rsp_latitude_microdeg,
   output logic [29:0] rsp_longitude_microdeg,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   logic [4:0]        zone_hours_ff, zone_hours_in;
   logic [5:0]        zone_minutes_ff, zone_minutes_in;
   logic              fin_busy;
   nggp_pkg::fix_type fix;

   always_comb begin
      zone_hours_in   = zone_hours_ff;
      zone_minutes_in = zone_minutes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            nggp_pkg::CSR_ZONE_HOURS:   zone_hours_in   = csr_wdata[4:0];
            nggp_pkg::CSR_ZONE_MINUTES: zone_minutes_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_hours_ff   <= 5'd4;
         zone_minutes_ff <= 6'd30;
      end else begin
         zone_hours_ff   <= zone_hours_in;
         zone_minutes_ff <= zone_minutes_in;
      end
   end

   nggp_parser #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .fin_busy      (fin_busy),
      .fix           (fix)
   );

   nggp_finish u_finish (
      .clock                  (clock),
      .reset                  (reset),
      .fix                    (fix),
      .zone_hours             (zone_hours_ff),
      .zone_minutes           (zone_minutes_ff),
      .fin_busy               (fin_busy),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_local_hour         (rsp_local_hour),
      .rsp_local_minute       (rsp_local_minute),
      .rsp_local_second       (rsp_local_second),
      .rsp_latitude_microdeg  (rsp_latitude_microdeg),
      .rsp_longitude_microdeg (rsp_longitude_microdeg)
   );

endmodule

// ----- rtl/core/nggp_parser.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA byte parser
// Walks the sentence one byte per transfer and accumulates time and position.
// ----------------------------------------------------------------------------
module nggp_parser #(
   parameter int FRACTION_DIGITS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_char_byte,
   input  logic             fin_busy,
   output nggp_pkg::fix_type fix
);

   typedef enum logic [3:0] {
      PH_HUNT, PH_HDR, PH_TIME, PH_TSKIP, PH_LATINT, PH_LATDOT, PH_LATFRAC,
      PH_NHEM, PH_NCOMMA, PH_LONINT, PH_LONDOT, PH_LONFRAC, PH_EHEM
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [2:0]                      hdr_idx_ff, hdr_idx_in;
   logic [2:0]                      digit_cnt_ff, digit_cnt_in;
   logic [6:0]                      hour_ff, hour_in;
   logic [6:0]                      min_ff, min_in;
   logic [6:0]                      sec_ff, sec_in;
   logic [6:0]                      lat_deg_ff, lat_deg_in;
   nggp_pkg::div60_type             lat_div_ff, lat_div_in;
   logic [9:0]                      lon_deg_ff, lon_deg_in;
   nggp_pkg::div60_type             lon_div_ff, lon_div_in;
   logic [nggp_pkg::FRAC_CNT_W-1:0] frac_cnt_ff, frac_cnt_in;
   logic [nggp_pkg::FRAC_CNT_W-1:0] lat_pad_ff, lat_pad_in;

   logic       accept;
   logic       is_digit;
   logic [3:0] digit;
   logic       frac_keep;

   // Only the east-hemisphere byte, which can complete a sentence, has to wait.
   assign req_ready = !(phase_ff == PH_EHEM && fin_busy);
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_char_byte >= nggp_pkg::CH_ZERO) && (req_char_byte <= nggp_pkg::CH_NINE);
   assign digit     = is_digit ? 4'(req_char_byte - nggp_pkg::CH_ZERO) : 4'd0;
   assign frac_keep = frac_cnt_ff < nggp_pkg::FRAC_CNT_W'(FRACTION_DIGITS);

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      digit_cnt_in = digit_cnt_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      lat_deg_in   = lat_deg_ff;
      lat_div_in   = lat_div_ff;
      lon_deg_in   = lon_deg_ff;
      lon_div_in   = lon_div_ff;
      frac_cnt_in  = frac_cnt_ff;
      lat_pad_in   = lat_pad_ff;
      if (accept) begin
         if (req_char_byte == nggp_pkg::CH_DOLLAR) begin
            phase_in   = PH_HDR;
            hdr_idx_in = 3'd0;
         end else begin
            unique case (phase_ff)
               PH_HDR: begin
                  if (req_char_byte == nggp_pkg::hdr_char(hdr_idx_ff)) begin
                     hdr_idx_in = hdr_idx_ff + 3'd1;
                     if (hdr_idx_ff == 3'd5) begin
                        phase_in     = PH_TIME;
                        digit_cnt_in = 3'd0;
                        hour_in      = 7'd0;
                        min_in       = 7'd0;
                        sec_in       = 7'd0;
                        lat_deg_in   = 7'd0;
                        lat_div_in   = '0;
                        lon_deg_in   = 10'd0;
                        lon_div_in   = '0;
                        frac_cnt_in  = '0;
                     end
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_TIME: begin
                  if (!is_digit) begin
                     phase_in = PH_HUNT;
                  end else begin
                     if (digit_cnt_ff < 3'd2) begin
                        hour_in = 7'(hour_ff * 7'd10) + 7'(digit);
                     end else if (digit_cnt_ff < 3'd4) begin
                        min_in = 7'(min_ff * 7'd10) + 7'(digit);
                     end else begin
                        sec_in = 7'(sec_ff * 7'd10) + 7'(digit);
                     end
                     digit_cnt_in = digit_cnt_ff + 3'd1;
                     if (digit_cnt_ff == 3'd5) begin
                        if (hour_ff > 7'd23 || min_ff > 7'd59 || sec_in > 7'd60) begin
                           phase_in = PH_HUNT;
                        end else begin
                           phase_in = PH_TSKIP;
                        end
                     end
                  end
               end
               PH_TSKIP: begin
                  if (req_char_byte == nggp_pkg::CH_COMMA) begin
                     phase_in     = PH_LATINT;
                     digit_cnt_in = 3'd0;
                  end
               end
               PH_LATINT: begin
                  if (!is_digit) begin
                     phase_in = PH_HUNT;
                  end else begin
                     if (digit_cnt_ff < 3'd2) begin
                        lat_deg_in = 7'(lat_deg_ff * 7'd10) + 7'(digit);
                     end else begin
                        lat_div_in = nggp_pkg::div60_step(lat_div_ff, digit);
                     end
                     digit_cnt_in = digit_cnt_ff + 3'd1;
                     if (digit_cnt_ff == 3'd3) begin
                        phase_in = PH_LATDOT;
                     end
                  end
               end
               PH_LATDOT: begin
                  if (req_char_byte == nggp_pkg::CH_DOT) begin
                     phase_in    = PH_LATFRAC;
                     frac_cnt_in = '0;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_LATFRAC: begin
                  if (is_digit) begin
                     if (frac_keep) begin
                        lat_div_in  = nggp_pkg::div60_step(lat_div_ff, digit);
                        frac_cnt_in = frac_cnt_ff + 1'b1;
                     end
                  end else if (req_char_byte == nggp_pkg::CH_COMMA) begin
                     // The missing fraction digits are appended later as zeros.
                     lat_pad_in = nggp_pkg::TOTAL_FRAC - frac_cnt_ff;
                     phase_in   = PH_NHEM;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_NHEM: begin
                  phase_in = (req_char_byte == nggp_pkg::CH_N) ? PH_NCOMMA : PH_HUNT;
               end
               PH_NCOMMA: begin
                  if (req_char_byte == nggp_pkg::CH_COMMA) begin
                     phase_in     = PH_LONINT;
                     digit_cnt_in = 3'd0;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_LONINT: begin
                  if (!is_digit) begin
                     phase_in = PH_HUNT;
                  end else begin
                     if (digit_cnt_ff < 3'd3) begin
                        lon_deg_in = 10'(lon_deg_ff * 10'd10) + 10'(digit);
                     end else begin
                        lon_div_in = nggp_pkg::div60_step(lon_div_ff, digit);
                     end
                     digit_cnt_in = digit_cnt_ff + 3'd1;
                     if (digit_cnt_ff == 3'd4) begin
                        phase_in = PH_LONDOT;
                     end
                  end
               end
               PH_LONDOT: begin
                  if (req_char_byte == nggp_pkg::CH_DOT) begin
                     phase_in    = PH_LONFRAC;
                     frac_cnt_in = '0;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_LONFRAC: begin
                  if (is_digit) begin
                     if (frac_keep) begin
                        lon_div_in  = nggp_pkg::div60_step(lon_div_ff, digit);
                        frac_cnt_in = frac_cnt_ff + 1'b1;
                     end
                  end else if (req_char_byte == nggp_pkg::CH_COMMA) begin
                     phase_in = PH_EHEM;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
               PH_EHEM: begin
                  phase_in = PH_HUNT;
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         hdr_idx_ff   <= 3'd0;
         digit_cnt_ff <= 3'd0;
         hour_ff      <= 7'd0;
         min_ff       <= 7'd0;
         sec_ff       <= 7'd0;
         lat_deg_ff   <= 7'd0;
         lat_div_ff   <= '0;
         lon_deg_ff   <= 10'd0;
         lon_div_ff   <= '0;
         frac_cnt_ff  <= '0;
         lat_pad_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         digit_cnt_ff <= digit_cnt_in;
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         lat_deg_ff   <= lat_deg_in;
         lat_div_ff   <= lat_div_in;
         lon_deg_ff   <= lon_deg_in;
         lon_div_ff   <= lon_div_in;
         frac_cnt_ff  <= frac_cnt_in;
         lat_pad_ff   <= lat_pad_in;
      end
   end

   assign fix.start   = accept && phase_ff == PH_EHEM && req_char_byte == nggp_pkg::CH_E;
   assign fix.hour    = hour_ff;
   assign fix.minute  = min_ff;
   assign fix.second  = sec_ff;
   assign fix.lat_deg = lat_deg_ff;
   assign fix.lat_div = lat_div_ff;
   assign fix.lat_pad = lat_pad_ff;
   assign fix.lon_deg = lon_deg_ff;
   assign fix.lon_div = lon_div_ff;
   assign fix.lon_pad = nggp_pkg::TOTAL_FRAC - frac_cnt_ff;

   a_dollar_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_char_byte == nggp_pkg::CH_DOLLAR) |=>
         (phase_ff == PH_HDR && hdr_idx_ff == 3'd0))
      else $error("dollar sign did not restart the header match");

   a_fix_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      fix.start |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunting after a complete sentence");

endmodule

// ----- rtl/core/nggp_finish.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA result unit
// Pads the minute fractions, converts positions to microdegrees, applies the
// zone offset and holds the result until it is transferred.
// ----------------------------------------------------------------------------
module nggp_finish (
   input  logic              clock,
   input  logic              reset,
   input  nggp_pkg::fix_type fix,
   input  logic [4:0]        zone_hours,
   input  logic [5:0]        zone_minutes,
   output logic              fin_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        rsp_local_hour,
   output logic [5:0]        rsp_local_minute,
   output logic [5:0]        rsp_local_second,
   output logic [26:0]       rsp_latitude_microdeg,
   output logic [29:0]       rsp_longitude_microdeg
);

   typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_MUL, ST_SUM} state_type;

   state_type                       state_ff, state_in;
   logic                            valid_ff, valid_in;
   logic [4:0]                      hour_ff, hour_in;
   logic [5:0]                      min_ff, min_in;
   logic [5:0]                      sec_ff, sec_in;
   logic [6:0]                      lat_deg_ff, lat_deg_in;
   logic [9:0]                      lon_deg_ff, lon_deg_in;
   nggp_pkg::div60_type             lat_div_ff, lat_div_in;
   nggp_pkg::div60_type             lon_div_ff, lon_div_in;
   logic [nggp_pkg::FRAC_CNT_W-1:0] lat_pad_ff, lat_pad_in;
   logic [nggp_pkg::FRAC_CNT_W-1:0] lon_pad_ff, lon_pad_in;
   logic [26:0]                     lat_prod_ff, lat_prod_in;
   logic [29:0]                     lon_prod_ff, lon_prod_in;
   logic [26:0]                     lat_out_ff, lat_out_in;
   logic [29:0]                     lon_out_ff, lon_out_in;
   logic [4:0]                      hour_out_ff, hour_out_in;
   logic [5:0]                      min_out_ff, min_out_in;
   logic [5:0]                      sec_out_ff, sec_out_in;

   logic [7:0] msum, msum1, msum2;
   logic [1:0] carry;
   logic [6:0] hsum, hsum1, hsum2;
   logic       out_free;

   // Zone offset: the minute sum carries at most twice, the hour sum wraps at most twice.
   always_comb begin
      msum  = 8'(fix.minute) + 8'(zone_minutes);
      msum1 = (msum >= 8'd60) ? msum - 8'd60 : msum;
      msum2 = (msum1 >= 8'd60) ? msum1 - 8'd60 : msum1;
      carry = 2'(msum >= 8'd60) + 2'(msum1 >= 8'd60);
      hsum  = fix.hour + 7'(zone_hours) + 7'(carry);
      hsum1 = (hsum >= 7'd24) ? hsum - 7'd24 : hsum;
      hsum2 = (hsum1 >= 7'd24) ? hsum1 - 7'd24 : hsum1;
   end

   assign out_free = !valid_ff || rsp_ready;
   assign fin_busy = state_ff != ST_IDLE;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff && !rsp_ready;
      hour_in     = hour_ff;
      min_in      = min_ff;
      sec_in      = sec_ff;
      lat_deg_in  = lat_deg_ff;
      lon_deg_in  = lon_deg_ff;
      lat_div_in  = lat_div_ff;
      lon_div_in  = lon_div_ff;
      lat_pad_in  = lat_pad_ff;
      lon_pad_in  = lon_pad_ff;
      lat_prod_in = lat_prod_ff;
      lon_prod_in = lon_prod_ff;
      lat_out_in  = lat_out_ff;
      lon_out_in  = lon_out_ff;
      hour_out_in = hour_out_ff;
      min_out_in  = min_out_ff;
      sec_out_in  = sec_out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fix.start) begin
               state_in   = ST_PAD;
               hour_in    = 5'(hsum2);
               min_in     = 6'(msum2);
               sec_in     = 6'(fix.second);
               lat_deg_in = fix.lat_deg;
               lon_deg_in = fix.lon_deg;
               lat_div_in = fix.lat_div;
               lon_div_in = fix.lon_div;
               lat_pad_in = fix.lat_pad;
               lon_pad_in = fix.lon_pad;
            end
         end
         ST_PAD: begin
            // Each cycle appends one zero digit to whichever fraction is short.
            if (lat_pad_ff != '0) begin
               lat_div_in = nggp_pkg::div60_step(lat_div_ff, 4'd0);
               lat_pad_in = lat_pad_ff - 1'b1;
            end
            if (lon_pad_ff != '0) begin
               lon_div_in = nggp_pkg::div60_step(lon_div_ff, 4'd0);
               lon_pad_in = lon_pad_ff - 1'b1;
            end
            if (lat_pad_ff == '0 && lon_pad_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            lat_prod_in = 27'(lat_deg_ff * 27'd1000000);
            lon_prod_in = 30'(lon_deg_ff * 30'd1000000);
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            if (out_free) begin
               lat_out_in  = lat_prod_ff + 27'(lat_div_ff.quo);
               lon_out_in  = lon_prod_ff + 30'(lon_div_ff.quo);
               hour_out_in = hour_ff;
               min_out_in  = min_ff;
               sec_out_in  = sec_ff;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      sec_ff      <= sec_in;
      lat_deg_ff  <= lat_deg_in;
      lon_deg_ff  <= lon_deg_in;
      lat_div_ff  <= lat_div_in;
      lon_div_ff  <= lon_div_in;
      lat_pad_ff  <= lat_pad_in;
      lon_pad_ff  <= lon_pad_in;
      lat_prod_ff <= lat_prod_in;
      lon_prod_ff <= lon_prod_in;
      lat_out_ff  <= lat_out_in;
      lon_out_ff  <= lon_out_in;
      hour_out_ff <= hour_out_in;
      min_out_ff  <= min_out_in;
      sec_out_ff  <= sec_out_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_local_hour         = hour_out_ff;
   assign rsp_local_minute       = min_out_ff;
   assign rsp_local_second       = sec_out_ff;
   assign rsp_latitude_microdeg  = lat_out_ff;
   assign rsp_longitude_microdeg = lon_out_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      fix.start |-> (state_ff == ST_IDLE))
      else $error("sentence completed while the result unit was busy");

   a_pad_counts_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && lat_pad_ff != '0) |=> (lat_pad_ff == $past(lat_pad_ff) - 1'b1))
      else $error("latitude padding count did not step down");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (hour_out_ff < 5'd24 && min_out_ff < 6'd60))
      else $error("local time out of range");

endmodule
